[design/mcmq_pkg.sv]
// Shared types and field widths for the multi-channel mailbox queue.
`default_nettype none

package mcmq_pkg;

    localparam int CH_FIELD_W   = 2;
    localparam int PAYLOAD_W    = 32;
    localparam int SENDER_W     = 2;
    localparam int PKT_W        = PAYLOAD_W + SENDER_W;
    localparam int IN_TDATA_W   = 40;
    localparam int OUT_TDATA_W  = 40;
    localparam int CH_WIDE_W    = 7;

    typedef enum logic [0:0] {
        CMD_SEND = 1'b0,
        CMD_RECV = 1'b1
    } cmd_t;

    typedef struct packed {
        logic [SENDER_W-1:0]  sender;
        logic [PAYLOAD_W-1:0] payload;
    } mbox_packet_t;

endpackage

`default_nettype wire

[design/multi_channel_mailbox_queue_unit.sv]
// Multi-channel mailbox: per-channel circular packet queues in one shared RAM.
//
//  channel  | dir | tdata (low bit up)                          | tuser
//  s_axis   | in  | channel[1:0], payload_in[33:2], sender_in[35:34] | cmd
//  m_axis   | out | payload_out[31:0], sender_out[33:32]        | success
//
//  One transaction per cycle sustained while m_axis_tready stays high; each
//  passes the input register, then the RAM registered read into the result stage.
//  Head and count per channel sit in flops, cleared by rst_n; packet RAM
//  is not cleared.
//  A result held by m_axis_tready low freezes both stages; s_axis_tready
//  stays high while the input stage is empty or can advance.
`default_nettype none

module multi_channel_mailbox_queue_unit
    import mcmq_pkg::*;
#(
    parameter int NUM_CHANNELS = 4,
    parameter int CAPACITY     = 16
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // channel, payload_in, sender_in, zero pad
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // cmd
    input  wire logic                   s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // payload_out, sender_out, zero pad
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    // success
    output logic                        m_axis_tuser
);

    localparam int CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int HEAD_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int SUM_W  = CNT_W + 1;
    localparam int DEPTH  = NUM_CHANNELS * CAPACITY;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic                  va_reg;
    cmd_t                  cmd_reg;
    logic [CH_FIELD_W-1:0] ch_reg;
    mbox_packet_t          pkt_reg;

    logic                  vb_reg;
    logic                  ok_b_reg;
    cmd_t                  cmd_b_reg;

    logic [HEAD_W-1:0]     head_reg [NUM_CHANNELS];
    logic [CNT_W-1:0]      cnt_reg  [NUM_CHANNELS];

    logic                  adv_a;
    logic [CH_WIDE_W-1:0]  ch_wide;
    logic [CH_W-1:0]       ch_idx;
    logic                  in_range;
    logic [HEAD_W-1:0]     head_cur;
    logic [CNT_W-1:0]      cnt_cur;
    logic [SUM_W-1:0]      tail_sum;
    logic [HEAD_W-1:0]     tail_slot;
    logic [HEAD_W-1:0]     head_next;
    logic                  do_send;
    logic                  do_recv;
    logic                  ok_a;
    logic [ADDR_W-1:0]     ch_base;
    logic [ADDR_W-1:0]     wr_addr;
    logic [ADDR_W-1:0]     rd_addr;
    mbox_packet_t          rd_pkt;
    logic                  ram_we;
    logic                  ram_re;

    assign adv_a         = va_reg && (!vb_reg || m_axis_tready);
    assign s_axis_tready = !va_reg || adv_a;

    assign ch_wide  = CH_WIDE_W'(ch_reg);
    assign ch_idx   = ch_wide[CH_W-1:0];
    assign in_range = ch_wide < CH_WIDE_W'(NUM_CHANNELS);
    assign head_cur = head_reg[ch_idx];
    assign cnt_cur  = cnt_reg[ch_idx];

    assign tail_sum  = SUM_W'(head_cur) + SUM_W'(cnt_cur);
    assign tail_slot = (tail_sum >= SUM_W'(CAPACITY))
                       ? HEAD_W'(tail_sum - SUM_W'(CAPACITY))
                       : HEAD_W'(tail_sum);
    assign head_next = (head_cur == HEAD_W'(CAPACITY - 1)) ? '0 : head_cur + HEAD_W'(1);

    assign do_send = in_range && (cmd_reg == CMD_SEND) && (cnt_cur != CNT_W'(CAPACITY));
    assign do_recv = in_range && (cmd_reg == CMD_RECV) && (cnt_cur != '0);
    assign ok_a    = do_send || do_recv;

    assign ch_base = ADDR_W'(ch_idx) * ADDR_W'(CAPACITY);
    assign wr_addr = ch_base + ADDR_W'(tail_slot);
    assign rd_addr = ch_base + ADDR_W'(head_cur);
    assign ram_we  = adv_a && do_send;
    assign ram_re  = adv_a && do_recv;

    mcmq_ram #(
        .WIDTH (PKT_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (wr_addr),
        .wr_data (pkt_reg),
        .rd_en   (ram_re),
        .rd_addr (rd_addr),
        .rd_data (rd_pkt)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            va_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            cmd_reg        <= cmd_t'(s_axis_tuser);
            ch_reg         <= s_axis_tdata[CH_FIELD_W-1:0];
            pkt_reg.payload <= s_axis_tdata[CH_FIELD_W +: PAYLOAD_W];
            pkt_reg.sender  <= s_axis_tdata[CH_FIELD_W + PAYLOAD_W +: SENDER_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                head_reg[i] <= '0;
                cnt_reg[i]  <= '0;
            end
        end
        else if (adv_a)
        begin
            if (do_send)
            begin
                cnt_reg[ch_idx] <= cnt_cur + CNT_W'(1);
            end
            else if (do_recv)
            begin
                cnt_reg[ch_idx]  <= cnt_cur - CNT_W'(1);
                head_reg[ch_idx] <= head_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vb_reg    <= 1'b0;
            ok_b_reg  <= 1'b0;
            cmd_b_reg <= CMD_SEND;
        end
        else if (adv_a)
        begin
            vb_reg    <= 1'b1;
            ok_b_reg  <= ok_a;
            cmd_b_reg <= cmd_reg;
        end
        else if (m_axis_tready)
        begin
            vb_reg <= 1'b0;
        end
    end

    always_comb
    begin
        m_axis_tvalid = vb_reg;
        m_axis_tuser  = ok_b_reg;
        m_axis_tdata  = '0;
        if (ok_b_reg && (cmd_b_reg == CMD_RECV))
        begin
            m_axis_tdata[PAYLOAD_W-1:0]          = rd_pkt.payload;
            m_axis_tdata[PAYLOAD_W +: SENDER_W]  = rd_pkt.sender;
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        va_reg |-> (cnt_cur <= CNT_W'(CAPACITY)))
        else $error("channel count above capacity");

    a_ok_carried: assert property (@(posedge clk) disable iff (!rst_n)
        adv_a |=> (vb_reg && (ok_b_reg == $past(ok_a))))
        else $error("result flag lost between stages");

    a_ram_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("RAM written and read by one transaction");

    a_stall_only: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (va_reg && vb_reg && !m_axis_tready))
        else $error("input stalled without output backpressure");

endmodule

`default_nettype wire

[design/mcmq_ram.sv]
// Generic simple dual-port RAM with registered read.
`default_nettype none

module mcmq_ram #(
    parameter int WIDTH = 34,
    parameter int DEPTH = 64
) (
    input  wire logic                                     clk,
    input  wire logic                                     wr_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                         wr_data,
    input  wire logic                                     rd_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[bench/tb_multi_channel_mailbox_queue_unit.sv]
// Self-checking testbench for the multi-channel mailbox queue: directed table, random traffic.
module tb_multi_channel_mailbox_queue_unit
    import mcmq_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_CH      = 4;
    localparam int CAP         = 16;
    localparam int DIRECTED_N  = 25;
    localparam int RANDOM_N    = 1150;
    localparam int BURST_LEN   = 50;
    localparam int IDLE_PCT    = 24;
    localparam int DRAIN_WAIT  = 8;
    localparam int CYCLE_LIMIT = 200000;
    localparam int IN_PAD_W    = IN_TDATA_W - CH_FIELD_W - PAYLOAD_W - SENDER_W;

    typedef struct packed {
        logic                 success;
        logic [PAYLOAD_W-1:0] payload;
        logic [SENDER_W-1:0]  sender;
    } mailbox_reply_t;

    typedef struct {
        cmd_t                  cmd;
        logic [CH_FIELD_W-1:0] channel;
        logic [PAYLOAD_W-1:0]  payload;
        logic [SENDER_W-1:0]   sender;
        bit                    typed;
        mailbox_reply_t        reply;
    } stim_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tuser;

    logic [3:0]           head_slot [NUM_CH];
    logic [4:0]           fill_level [NUM_CH];
    logic [PAYLOAD_W-1:0] payload_mem [NUM_CH*CAP];
    logic [SENDER_W-1:0]  sender_mem [NUM_CH*CAP];

    mailbox_reply_t expected_replies [$];
    stim_row_t      directed_rows [DIRECTED_N];
    bit             steady = 1'b0;
    int             errors = 0;
    int             cycle_count = 0;

    multi_channel_mailbox_queue_unit #(
        .NUM_CHANNELS (NUM_CH),
        .CAPACITY     (CAP)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #1 clk = ~clk;

    function automatic mailbox_reply_t predict_mailbox_reply(
        input cmd_t                  cmd,
        input logic [CH_FIELD_W-1:0] ch,
        input logic [PAYLOAD_W-1:0]  pay,
        input logic [SENDER_W-1:0]   snd
    );
        mailbox_reply_t r;
        int base;
        int slot;
        r = '0;
        if (int'(ch) < NUM_CH)
        begin
            base = int'(ch) * CAP;
            if (cmd == CMD_SEND)
            begin
                if (int'(fill_level[ch]) < CAP)
                begin
                    slot = (int'(head_slot[ch]) + int'(fill_level[ch])) % CAP;
                    payload_mem[base + slot] = pay;
                    sender_mem[base + slot] = snd;
                    fill_level[ch] = fill_level[ch] + 5'd1;
                    r.success = 1'b1;
                end
            end
            else if (fill_level[ch] != 5'd0)
            begin
                slot = int'(head_slot[ch]);
                r.success = 1'b1;
                r.payload = payload_mem[base + slot];
                r.sender = sender_mem[base + slot];
                head_slot[ch] = 4'((slot + 1) % CAP);
                fill_level[ch] = fill_level[ch] - 5'd1;
            end
        end
        return r;
    endfunction

    function automatic stim_row_t make_row(
        input cmd_t                  cmd,
        input logic [CH_FIELD_W-1:0] ch,
        input logic [PAYLOAD_W-1:0]  pay,
        input logic [SENDER_W-1:0]   snd,
        input bit                    typed,
        input logic                  succ,
        input logic [PAYLOAD_W-1:0]  pout,
        input logic [SENDER_W-1:0]   sout
    );
        stim_row_t row;
        row.cmd = cmd;
        row.channel = ch;
        row.payload = pay;
        row.sender = snd;
        row.typed = typed;
        row.reply.success = succ;
        row.reply.payload = pout;
        row.reply.sender = sout;
        return row;
    endfunction

    task automatic offer_transaction(
        input cmd_t                  cmd,
        input logic [CH_FIELD_W-1:0] ch,
        input logic [PAYLOAD_W-1:0]  pay,
        input logic [SENDER_W-1:0]   snd,
        input bit                    typed,
        input mailbox_reply_t        typed_reply
    );
        mailbox_reply_t predicted;
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {{IN_PAD_W{1'b0}}, snd, pay, ch};
        s_axis_tuser <= cmd;
        do @(posedge clk); while (!s_axis_tready);
        predicted = predict_mailbox_reply(cmd, ch, pay, snd);
        expected_replies.push_back(typed ? typed_reply : predicted);
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin : reply_monitor
        mailbox_reply_t got;
        mailbox_reply_t want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.success = m_axis_tuser;
                got.payload = m_axis_tdata[PAYLOAD_W-1:0];
                got.sender = m_axis_tdata[PAYLOAD_W +: SENDER_W];
                if (expected_replies.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %0h", $time, got);
                    errors++;
                end
                else
                begin
                    want = expected_replies.pop_front();
                    compare_field("success", 32'(want.success), 32'(got.success));
                    compare_field("payload_out", want.payload, got.payload);
                    compare_field("sender_out", 32'(want.sender), 32'(got.sender));
                end
            end
            m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
        else
        begin
            m_axis_tready <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     expected_replies.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        int                    i;
        int                    b;
        int                    k;
        int                    send_pct;
        int                    focus;
        bit                    focused;
        cmd_t                  cmd;
        logic [CH_FIELD_W-1:0] ch;
        logic [PAYLOAD_W-1:0]  pay;

        rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        s_axis_tuser <= 1'b0;

        for (i = 0; i < NUM_CH; i++)
        begin
            head_slot[i] = '0;
            fill_level[i] = '0;
        end

        directed_rows[0] = make_row(CMD_RECV, 2'd0, 32'h0, 2'd0, 1'b1, 1'b0, 32'h0, 2'd0);
        directed_rows[1] = make_row(CMD_RECV, 2'd3, 32'hFFFF_FFFF, 2'd3, 1'b1,
                                    1'b0, 32'h0, 2'd0);
        directed_rows[2] = make_row(CMD_SEND, 2'd0, 32'hFFFF_FFFF, 2'd3, 1'b1,
                                    1'b1, 32'h0, 2'd0);
        directed_rows[3] = make_row(CMD_SEND, 2'd0, 32'h0, 2'd0, 1'b1, 1'b1, 32'h0, 2'd0);
        directed_rows[4] = make_row(CMD_SEND, 2'd2, 32'h5555_AAAA, 2'd2, 1'b0,
                                    1'b0, 32'h0, 2'd0);
        directed_rows[5] = make_row(CMD_RECV, 2'd0, 32'h0, 2'd0, 1'b1,
                                    1'b1, 32'hFFFF_FFFF, 2'd3);
        directed_rows[6] = make_row(CMD_RECV, 2'd0, 32'h0, 2'd0, 1'b1, 1'b1, 32'h0, 2'd0);
        directed_rows[7] = make_row(CMD_RECV, 2'd0, 32'h0, 2'd0, 1'b1, 1'b0, 32'h0, 2'd0);
        for (i = 0; i < CAP; i++)
            directed_rows[8 + i] = make_row(CMD_SEND, 2'd1, 32'hC0DE_0000 + 32'(i), 2'(i),
                                            1'b0, 1'b0, 32'h0, 2'd0);
        directed_rows[8 + CAP] = make_row(CMD_SEND, 2'd1, 32'h1234_5678, 2'd1, 1'b1,
                                          1'b0, 32'h0, 2'd0);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < DIRECTED_N; i++)
            offer_transaction(directed_rows[i].cmd, directed_rows[i].channel,
                              directed_rows[i].payload, directed_rows[i].sender,
                              directed_rows[i].typed, directed_rows[i].reply);

        for (b = 0; b < RANDOM_N / BURST_LEN; b++)
        begin
            steady <= (b >= 8 && b < 12);
            case ($urandom_range(2))
                0: send_pct = 80;
                1: send_pct = 50;
                default: send_pct = 20;
            endcase
            focused = $urandom_range(1);
            focus = $urandom_range(NUM_CH - 1);
            for (k = 0; k < BURST_LEN; k++)
            begin
                cmd = ($urandom_range(99) < send_pct) ? CMD_SEND : CMD_RECV;
                ch = (focused && $urandom_range(9) != 0) ? 2'(focus) : 2'($urandom_range(3));
                case ($urandom_range(15))
                    0: pay = '0;
                    1: pay = '1;
                    default: pay = $urandom();
                endcase
                offer_transaction(cmd, ch, pay, 2'($urandom_range(3)), 1'b0, '0);
            end
        end
        s_axis_tvalid <= 1'b0;
        steady <= 1'b0;

        while (expected_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

[files.f]
design/mcmq_pkg.sv
design/mcmq_ram.sv
design/multi_channel_mailbox_queue_unit.sv
bench/tb_multi_channel_mailbox_queue_unit.sv
